FILE: hdl/list_mode_buffer_parser_assert.svh
// ---------------------------------------------------------------------------
// list mode buffer parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef LIST_MODE_BUFFER_PARSER_ASSERT_SVH
`define LIST_MODE_BUFFER_PARSER_ASSERT_SVH

// same-cycle implication
`define LMBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LMBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lmbp_pkg.sv
// ---------------------------------------------------------------------------
// lmbp_pkg
// types, codes and record builders of the list mode buffer parser
// ---------------------------------------------------------------------------
package lmbp_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [3:0] {
    PH_LEN, PH_MOD, PH_FMT, PH_BTH, PH_BTM, PH_BTL, PH_HIT, PH_ETH, PH_ETL,
    PH_FT, PH_EN, PH_CF, PH_SKW, PH_SKIP_MOD, PH_SKIP_BAD, PH_SKIP_SUB
  } phase_t;

  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_LENGTH  = 3'd1;
  localparam logic [2:0] ERR_MODULE  = 3'd2;
  localparam logic [2:0] ERR_FORMAT  = 3'd3;
  localparam logic [2:0] ERR_EVENTS  = 3'd4;
  localparam logic [2:0] ERR_PATTERN = 3'd5;

  localparam logic [2:0] CFG_MODULES = 3'd0;
  localparam logic [2:0] CFG_MAX_EV  = 3'd1;
  localparam logic [2:0] CFG_FMT_A   = 3'd2;
  localparam logic [2:0] CFG_FMT_B   = 3'd3;
  localparam logic [2:0] CFG_FMT_C   = 3'd4;

  typedef struct packed {
    logic [6:0]  modules_in_use;
    logic [15:0] max_events;
    logic [15:0] format_code_a;
    logic [15:0] format_code_b;
    logic [15:0] format_code_c;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [5:0]  module_res;
    logic [15:0] event_index;
    logic [1:0]  channel;
    logic [47:0] event_time;
    logic [47:0] trigger_time;
    logic [15:0] energy;
    logic [15:0] cf_time;
    logic [15:0] event_count;
  } rec_t;

  // records caused by one word: cnt of them, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r0;
    rec_t       r1;
  } bundle_t;

  function automatic rec_t mk_err(logic [2:0] code, logic [5:0] m, logic [15:0] ev);
    rec_t r;
    r            = '0;
    r.kind       = KIND_ERR;
    r.error_code = code;
    r.module_res = m;
    r.event_index = ev;
    return r;
  endfunction

endpackage

FILE: hdl/lmbp_if.sv
// ---------------------------------------------------------------------------
// lmbp channel interfaces
// word input channel and record output channel with valid/ready
// ---------------------------------------------------------------------------
interface lmbp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic        first_word;
  logic [15:0] subevent_words;
  modport source (output valid, data_word, first_word, subevent_words, input ready);
  modport sink (input valid, data_word, first_word, subevent_words, output ready);
endinterface

interface lmbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [5:0]  module_res;
  logic [15:0] event_index;
  logic [1:0]  channel;
  logic [47:0] event_time;
  logic [47:0] trigger_time;
  logic [15:0] energy;
  logic [15:0] cf_time;
  logic [15:0] event_count;
  modport source (output valid, kind, error_code, module_res, event_index, channel,
                  event_time, trigger_time, energy, cf_time, event_count, input ready);
  modport sink (input valid, kind, error_code, module_res, event_index, channel,
                event_time, trigger_time, energy, cf_time, event_count, output ready);
endinterface

FILE: hdl/lmbp_front.sv
// ---------------------------------------------------------------------------
// lmbp_front
// word parser: one word a cycle when take is high, emits a bundle of up to two records
// ---------------------------------------------------------------------------
module lmbp_front #(
  parameter int CHANNELS = lmbp_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lmbp_pkg::cfg_t   cfg,
  input  logic             take,
  input  logic [15:0]      word,
  input  logic             first,
  input  logic [15:0]      sub_words,
  output logic             push,
  output lmbp_pkg::bundle_t bundle
);
  import lmbp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] sub_left_r, sub_left_nxt;
  logic [15:0] mod_left_r, mod_left_nxt;
  logic [5:0]  cur_mod_r, cur_mod_nxt;
  logic        cur_fmt_r, cur_fmt_nxt;
  logic [47:0] bt_r, bt_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [47:0] et_r, et_nxt;
  logic [15:0] trig_r, trig_nxt;
  logic [15:0] en_r, en_nxt;
  logic [15:0] ev_r, ev_nxt;
  logic        pad_r, pad_nxt;

  logic [15:0] sl, ml, mnum;
  phase_t      ph;
  logic        pd, has_a, has_done;
  rec_t        rec_a, rec_done;
  logic [3:0]  mask_tmp;

  // lowest set hit bit picks the next channel, else the event is complete
  function automatic logic [2:0] pick(logic [3:0] m);
    logic [2:0] r;
    r = 3'b000;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (m[c]) r = {1'b1, 2'(c)};
    end
    return r;
  endfunction

  function automatic rec_t mk_hit(logic [5:0] m, logic [15:0] ev, logic [1:0] ch,
                                  logic [47:0] et, logic [15:0] tw, logic [15:0] en,
                                  logic [15:0] cf);
    rec_t r;
    r              = '0;
    r.kind         = KIND_HIT;
    r.module_res   = m;
    r.event_index  = ev;
    r.channel      = ch;
    r.event_time   = et;
    r.trigger_time = {et[47:16], tw};
    r.energy       = en;
    r.cf_time      = cf;
    return r;
  endfunction

  always_comb begin
    logic [2:0] nc;
    phase_nxt = phase_r; sub_left_nxt = sub_left_r; mod_left_nxt = mod_left_r;
    cur_mod_nxt = cur_mod_r; cur_fmt_nxt = cur_fmt_r; bt_nxt = bt_r; mask_nxt = mask_r;
    ch_nxt = ch_r; et_nxt = et_r; trig_nxt = trig_r; en_nxt = en_r; ev_nxt = ev_r;
    pad_nxt = pad_r;
    has_a = 1'b0; has_done = 1'b0; rec_a = '0; rec_done = '0;
    nc = 3'b000; mnum = word - 16'd1; ml = mod_left_r; mask_tmp = mask_r;
    sl = first ? sub_words : sub_left_r;
    ph = first ? PH_LEN : phase_r;
    pd = first ? 1'b0 : pad_r;
    if (take) begin
      sub_left_nxt = sl;
      phase_nxt    = ph;
      pad_nxt      = pd;
      if (sl != 16'd0) begin
        sub_left_nxt = sl - 16'd1;
        if (ph == PH_SKIP_SUB) begin
          phase_nxt = PH_SKIP_SUB;
        end else if (ph == PH_LEN) begin
          if (pd) begin
            pad_nxt = 1'b0;
          end else if (word < 16'd2 || word > sl) begin
            has_a = 1'b1; rec_a = mk_err(ERR_LENGTH, 6'd0, ev_r);
            phase_nxt = PH_SKIP_SUB;
          end else begin
            mod_left_nxt = word - 16'd1;
            pad_nxt = word[0];
            ev_nxt = 16'd0;
            phase_nxt = PH_MOD;
          end
        end else begin
          case (ph)
            PH_MOD: begin
              if (mnum >= {9'd0, cfg.modules_in_use} || mnum[15:6] != 10'd0) begin
                has_a = 1'b1; rec_a = mk_err(ERR_MODULE, mnum[5:0], ev_r);
                phase_nxt = PH_SKIP_BAD;
              end else begin
                cur_mod_nxt = mnum[5:0];
                phase_nxt = PH_FMT;
              end
            end
            PH_FMT: begin
              if (word == cfg.format_code_b) begin
                cur_fmt_nxt = 1'b1; phase_nxt = PH_BTH;
              end else if (word == cfg.format_code_a || word == cfg.format_code_c) begin
                cur_fmt_nxt = 1'b0; phase_nxt = PH_BTH;
              end else begin
                has_a = 1'b1; rec_a = mk_err(ERR_FORMAT, cur_mod_r, ev_r);
                phase_nxt = PH_SKIP_MOD;
              end
            end
            PH_BTH: begin bt_nxt[47:32] = word; phase_nxt = PH_BTM; end
            PH_BTM: begin bt_nxt[31:16] = word; phase_nxt = PH_BTL; end
            PH_BTL: begin bt_nxt[15:0] = word; phase_nxt = PH_HIT; end
            PH_HIT: begin
              if (ev_r >= cfg.max_events) begin
                has_a = 1'b1; rec_a = mk_err(ERR_EVENTS, cur_mod_r, ev_r);
                phase_nxt = PH_SKIP_MOD;
              end else if ((word >> CHANNELS) != 16'd0) begin
                has_a = 1'b1; rec_a = mk_err(ERR_PATTERN, cur_mod_r, ev_r);
                phase_nxt = PH_SKIP_MOD;
              end else begin
                mask_nxt = word[3:0]; phase_nxt = PH_ETH;
              end
            end
            PH_ETH: begin
              // wrap against buffer time bumps the upper word
              et_nxt = {bt_r[47:32] + {15'd0, word < bt_r[31:16]}, word, 16'd0};
              phase_nxt = PH_ETL;
            end
            PH_ETL, PH_EN, PH_SKW: begin
              if (ph == PH_ETL) begin
                et_nxt[15:0] = word;
              end else begin
                mask_tmp[ch_r] = 1'b0;
              end
              if (ph == PH_EN) en_nxt = word;
              if (ph == PH_EN && cur_fmt_r) begin
                phase_nxt = PH_CF;
              end else begin
                if (ph == PH_EN) begin
                  has_a = 1'b1;
                  rec_a = mk_hit(cur_mod_r, ev_r, ch_r, et_r, trig_r, word, 16'd0);
                end
                mask_nxt = mask_tmp;
                nc = pick(mask_tmp);
                if (nc[2]) begin
                  ch_nxt = nc[1:0]; phase_nxt = PH_FT;
                end else begin
                  if (ev_r != 16'hFFFF) ev_nxt = ev_r + 16'd1;
                  phase_nxt = PH_HIT;
                end
              end
            end
            PH_FT: begin trig_nxt = word; phase_nxt = PH_EN; end
            PH_CF: begin
              has_a = 1'b1;
              rec_a = mk_hit(cur_mod_r, ev_r, ch_r, et_r, trig_r, en_r, word);
              phase_nxt = PH_SKW;
            end
            default: ;
          endcase
          if (ml != 16'd0) ml = ml - 16'd1;
          mod_left_nxt = ml;
          if (ml == 16'd0) begin
            if (phase_nxt != PH_SKIP_BAD && phase_nxt != PH_MOD) begin
              has_done = 1'b1;
              rec_done = '0;
              rec_done.kind = KIND_DONE;
              rec_done.module_res = cur_mod_nxt;
              rec_done.event_count = ev_nxt;
            end
            phase_nxt = PH_LEN;
          end
        end
      end
    end
    push = has_a || has_done;
    bundle.cnt = {1'b0, has_a} + {1'b0, has_done};
    bundle.r0  = has_a ? rec_a : rec_done;
    bundle.r1  = rec_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN; sub_left_r <= '0; mod_left_r <= '0; cur_mod_r <= '0;
      cur_fmt_r <= 1'b0; bt_r <= '0; mask_r <= '0; ch_r <= '0; et_r <= '0;
      trig_r <= '0; en_r <= '0; ev_r <= '0; pad_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; sub_left_r <= sub_left_nxt; mod_left_r <= mod_left_nxt;
      cur_mod_r <= cur_mod_nxt; cur_fmt_r <= cur_fmt_nxt; bt_r <= bt_nxt;
      mask_r <= mask_nxt; ch_r <= ch_nxt; et_r <= et_nxt; trig_r <= trig_nxt;
      en_r <= en_nxt; ev_r <= ev_nxt; pad_r <= pad_nxt;
    end
  end

endmodule

FILE: hdl/lmbp_queue.sv
// ---------------------------------------------------------------------------
// lmbp_queue
// short record-bundle queue between parser and output stage
// ---------------------------------------------------------------------------
module lmbp_queue #(
  parameter int DEPTH = lmbp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lmbp_pkg::bundle_t push_data,
  input  logic              pop,
  output logic              nonempty,
  output logic              full,
  output lmbp_pkg::bundle_t pop_data
);
  import lmbp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0; rptr_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      if (do_pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

FILE: hdl/lmbp_back.sv
// ---------------------------------------------------------------------------
// lmbp_back
// output stage: holds one bundle and hands its records out one by one
// ---------------------------------------------------------------------------
module lmbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  lmbp_pkg::bundle_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lmbp_pkg::rec_t    out_rec
);
  import lmbp_pkg::*;

  bundle_t bundle_r;
  logic    busy_r, idx_r;
  logic    fin, load;

  assign fin       = busy_r && out_ready && (idx_r || bundle_r.cnt != 2'd2);
  assign load      = !busy_r || fin;
  assign q_pop     = load && q_nonempty;
  assign out_valid = busy_r;
  assign out_rec   = idx_r ? bundle_r.r1 : bundle_r.r0;

  always_ff @(posedge clk) begin
    if (load && q_nonempty) bundle_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; idx_r <= 1'b0;
    end else if (load) begin
      busy_r <= q_nonempty; idx_r <= 1'b0;
    end else if (out_ready) begin
      idx_r <= 1'b1;
    end
  end

endmodule

FILE: hdl/list_mode_buffer_parser.sv
// ---------------------------------------------------------------------------
// list_mode_buffer_parser
// list-mode subevent decoder producing hit, module-done and error records
// ---------------------------------------------------------------------------
// Takes one 16-bit subevent word per cycle (in_ch.ready stays high unless the
// two-entry record queue is full) and parses module blocks, events and
// channels as each word is taken. A word causes at most two records, which go
// as one bundle into the queue; the output stage gives out one record per cycle
// while out_ch.ready is high. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module list_mode_buffer_parser #(
  parameter int CHANNELS_PER_MODULE = lmbp_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lmbp_in_if.sink           in_ch,
  lmbp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import lmbp_pkg::*;

  cfg_t    cfg_r;
  logic    take, push, q_full, q_nonempty, q_pop;
  bundle_t push_bundle, q_data;
  rec_t    rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modules_in_use <= 7'd16;
      cfg_r.max_events     <= 16'd256;
      cfg_r.format_code_a  <= 16'd257;
      cfg_r.format_code_b  <= 16'd258;
      cfg_r.format_code_c  <= 16'd259;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULES: cfg_r.modules_in_use <= cfg_data[6:0];
        CFG_MAX_EV:  cfg_r.max_events     <= cfg_data;
        CFG_FMT_A:   cfg_r.format_code_a  <= cfg_data;
        CFG_FMT_B:   cfg_r.format_code_b  <= cfg_data;
        CFG_FMT_C:   cfg_r.format_code_c  <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept a word whenever the queue can take a bundle
  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;

  lmbp_front #(.CHANNELS(CHANNELS_PER_MODULE)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .take(take), .word(in_ch.data_word),
    .first(in_ch.first_word), .sub_words(in_ch.subevent_words),
    .push(push), .bundle(push_bundle)
  );

  lmbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_bundle), .pop(q_pop),
    .nonempty(q_nonempty), .full(q_full), .pop_data(q_data)
  );

  lmbp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nonempty(q_nonempty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rec(rec)
  );

  assign out_ch.kind         = rec.kind;
  assign out_ch.error_code   = rec.error_code;
  assign out_ch.module_res   = rec.module_res;
  assign out_ch.event_index  = rec.event_index;
  assign out_ch.channel      = rec.channel;
  assign out_ch.event_time   = rec.event_time;
  assign out_ch.trigger_time = rec.trigger_time;
  assign out_ch.energy       = rec.energy;
  assign out_ch.cf_time      = rec.cf_time;
  assign out_ch.event_count  = rec.event_count;

  `include "list_mode_buffer_parser_assert.svh"

  // a bundle is never produced when the queue cannot hold it
  `LMBP_ASSERT_NOW(a_no_lost_bundle, push, !q_full, "record bundle dropped")
  // hit records carry no error code
  `LMBP_ASSERT_NOW(a_hit_clean, out_ch.valid && out_ch.kind == KIND_HIT,
                   out_ch.error_code == ERR_NONE, "hit record with error code")
  // a popped bundle is shown on the next cycle
  `LMBP_ASSERT_NEXT(a_pop_shows, q_pop, out_ch.valid, "popped bundle not shown")

endmodule
